// ----- rtl/skvt_pkg.sv -----
// Package for the sorted hash key/value table.
// Shared request codes, status codes, entry layout and controller/datapath structs.
// No dependencies.
package skvt_pkg;

  localparam int HASH_W  = 32;
  localparam int TYPE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 7;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 3;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd4;

  // Source of found_type / found_value in the response
  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_ENTRY = 2'd1;
  localparam logic [1:0] SEL_NEW   = 2'd2;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [TYPE_W-1:0]  vtype;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              cap_req;
    logic              rd_mid;
    logic              step;
    logic              rd_pos;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic [1:0]        res_sel;
    logic              shift_init;
    logic              rd_shift;
    logic              wr_shift;
    logic              wr_new;
    logic              inc_cnt;
    logic              clr_cnt;
    logic              load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             lo_lt_hi;
    logic             hit;
    logic             type_eq;
    logic             full;
    logic             shift_more;
    logic             out_free;
  } dp_stat_t;

endpackage

// ----- rtl/sorted_hash_key_value_table.sv -----
// Sorted hash key/value table. Holds up to CAPACITY entries (32-bit hash,
// 3-bit type, 32-bit value) in one RAM, sorted by ascending hash, and serves
// insert, lookup, update and clear requests one at a time. Each request
// returns exactly one response. A request runs a binary search whose compare
// step waits for the registered RAM read; a clear skips the search. A
// successful insert then moves every entry above the insertion point up by
// one through the single RAM read and write port, and then ends the shift
// and writes the new entry. A new request is accepted while the previous
// response still waits in the output register. No clearing pass is needed
// after reset.
// Depends on skvt_pkg, skvt_ctrl, skvt_datapath and skvt_ram.
module sorted_hash_key_value_table import skvt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key_hash[31:0], value_type[34:32], value_word[66:35]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[2:0], found_type[5:3], found_value[37:6],
                                  // entry_total[44:38]
);

  ctl_cmd_t           cmd;
  dp_stat_t           stat;
  logic [STAT_W-1:0]  out_status;
  logic [TYPE_W-1:0]  out_type;
  logic [VALUE_W-1:0] out_value;
  logic [TOTAL_W-1:0] out_total;

  skvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skvt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (in_tuser),
    .in_hash    (in_tdata[31:0]),
    .in_vtype   (in_tdata[34:32]),
    .in_vword   (in_tdata[66:35]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_type   (out_type),
    .out_value  (out_value),
    .out_total  (out_total)
  );

  assign out_tdata = {3'd0, out_total, out_value, out_type, out_status};

endmodule

// ----- rtl/skvt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/skvt_datapath.sv -----
// Datapath of the sorted hash table: request registers, binary-search bounds,
// entry count, shift index, table RAM and response register.
// Depends on skvt_pkg and skvt_ram.
module skvt_datapath import skvt_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic [REQ_W-1:0]    in_req,
  input  logic [HASH_W-1:0]   in_hash,
  input  logic [TYPE_W-1:0]   in_vtype,
  input  logic [VALUE_W-1:0]  in_vword,
  input  logic                out_tready,
  output logic                out_valid,
  output logic [STAT_W-1:0]   out_status,
  output logic [TYPE_W-1:0]   out_type,
  output logic [VALUE_W-1:0]  out_value,
  output logic [TOTAL_W-1:0]  out_total
);

  logic [REQ_W-1:0]   req_r;
  logic [HASH_W-1:0]  key_r;
  logic [TYPE_W-1:0]  vtype_r;
  logic [VALUE_W-1:0] vword_r;
  logic [CW-1:0]      lo_r, hi_r, idx_r, cnt_r;
  entry_t             ent_r;
  logic [STAT_W-1:0]  res_status_r;
  logic [1:0]         res_sel_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [TYPE_W-1:0]  out_type_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic [CW-1:0]         mid;
  logic [CW-1:0]         idx_dec;
  logic [CW+TOTAL_W-1:0] cnt_ext;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;
  entry_t                wdata, rdata, new_ent;
  logic [TYPE_W-1:0]     sel_type;
  logic [VALUE_W-1:0]    sel_value;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_dec = idx_r - CW'(1);
  assign cnt_ext = {{TOTAL_W{1'b0}}, cnt_r};
  assign new_ent = '{hash: key_r, vtype: vtype_r, value: vword_r};

  always_comb begin
    if (cmd.rd_mid) begin
      raddr = mid[AW-1:0];
    end else if (cmd.rd_shift) begin
      raddr = idx_dec[AW-1:0];
    end else begin
      raddr = lo_r[AW-1:0];
    end
  end

  assign we    = cmd.wr_shift | cmd.wr_new;
  assign waddr = cmd.wr_shift ? idx_r[AW-1:0] : lo_r[AW-1:0];
  assign wdata = cmd.wr_shift ? rdata : new_ent;

  skvt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (res_sel_r)
      SEL_ENTRY: begin
        sel_type  = ent_r.vtype;
        sel_value = ent_r.value;
      end
      SEL_NEW: begin
        sel_type  = vtype_r;
        sel_value = vword_r;
      end
      default: begin
        sel_type  = '0;
        sel_value = '0;
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      req_r   <= in_req;
      key_r   <= in_hash;
      vtype_r <= in_vtype;
      vword_r <= in_vword;
      lo_r    <= '0;
      hi_r    <= cnt_r;
    end
    if (cmd.step) begin
      if (rdata.hash < key_r) begin
        lo_r <= mid + CW'(1);
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.set_res) begin
      ent_r        <= rdata;
      res_status_r <= cmd.res_status;
      res_sel_r    <= cmd.res_sel;
    end
    if (cmd.shift_init) begin
      idx_r <= cnt_r;
    end else if (cmd.wr_shift) begin
      idx_r <= idx_dec;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_type_r   <= sel_type;
      out_value_r  <= sel_value;
      out_total_r  <= cnt_ext[TOTAL_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_cnt) begin
        cnt_r <= '0;
      end else if (cmd.inc_cnt) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.req        = req_r;
  assign stat.lo_lt_hi   = lo_r < hi_r;
  assign stat.hit        = (lo_r < cnt_r) && (rdata.hash == key_r);
  assign stat.type_eq    = rdata.vtype == vtype_r;
  assign stat.full       = cnt_r == CW'(CAPACITY);
  assign stat.shift_more = idx_r > lo_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_type   = out_type_r;
  assign out_value  = out_value_r;
  assign out_total  = out_total_r;

endmodule

// ----- rtl/skvt_ctrl.sv -----
// Controller state machine of the sorted hash table: sequences the binary
// search, the entry shift of an insert and the response. Depends on skvt_pkg.
module skvt_ctrl import skvt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SCMP  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_WNEW  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap_req = 1'b1;
          state_nxt   = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.req == REQ_CLEAR) begin
          cmd.clr_cnt    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_sel    = SEL_NONE;
          state_nxt      = S_RESP;
        end else if (stat.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_SCMP;
        end else begin
          // bounds met: fetch the entry at the insertion point
          cmd.rd_pos = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_SCMP: begin
        cmd.step  = 1'b1;
        state_nxt = S_SRCH;
      end
      S_CHECK: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_RESP;
        case (stat.req)
          REQ_INSERT: begin
            if (stat.hit) begin
              cmd.res_status = ST_DUP;
              cmd.res_sel    = SEL_ENTRY;
            end else if (stat.full) begin
              cmd.res_status = ST_FULL;
              cmd.res_sel    = SEL_NONE;
            end else begin
              cmd.res_status = ST_OK;
              cmd.res_sel    = SEL_NEW;
              cmd.shift_init = 1'b1;
              state_nxt      = S_SHIFT;
            end
          end
          REQ_UPDATE: begin
            if (!stat.hit) begin
              cmd.res_status = ST_NOTFOUND;
              cmd.res_sel    = SEL_NONE;
            end else if (!stat.type_eq) begin
              cmd.res_status = ST_MISMATCH;
              cmd.res_sel    = SEL_ENTRY;
            end else begin
              cmd.res_status = ST_OK;
              cmd.res_sel    = SEL_NEW;
              state_nxt      = S_WNEW;
            end
          end
          default: begin
            if (stat.hit) begin
              cmd.res_status = ST_OK;
              cmd.res_sel    = SEL_ENTRY;
            end else begin
              cmd.res_status = ST_NOTFOUND;
              cmd.res_sel    = SEL_NONE;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // move entries above the insertion point up by one, top first
        if (stat.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SHWR;
        end else begin
          state_nxt = S_WNEW;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_WNEW: begin
        cmd.wr_new  = 1'b1;
        cmd.inc_cnt = stat.req == REQ_INSERT;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/skvt_checker.sv -----
// Port-level checker for the sorted hash key/value table, bound to the top.
// Depends on skvt_pkg.
module skvt_checker import skvt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a request was accepted");

  a_hold_response: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled response dropped or changed");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_NOTFOUND || out_tdata[2:0] == ST_FULL)
      |-> out_tdata[37:3] == '0)
    else $error("entry fields not zero on a miss or full table");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_MISMATCH && out_tdata[47:45] == '0)
    else $error("bad status code or padding");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("response valid after reset");

endmodule

bind sorted_hash_key_value_table skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (.*);

// ----- bench/tb_sorted_hash_key_value_table.sv -----
`timescale 1ns / 100ps
// Self-checking bench for sorted_hash_key_value_table: directed requests, then random
// fill/search/update/clear episodes, each result checked against a local table model
// or, for typed directed rows, a fixed expected result. Depends on skvt_pkg and the RTL.
module tb_sorted_hash_key_value_table;
  import skvt_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_COUNT = 1200;
  localparam int STALL_CYCLES = 400;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TYPE_W-1:0]  ftype;
    logic [VALUE_W-1:0] fvalue;
    logic [TOTAL_W-1:0] total;
  } tbl_result_t;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [HASH_W-1:0]  key;
    logic [TYPE_W-1:0]  vtype;
    logic [VALUE_W-1:0] vword;
    bit                 typed;
    tbl_result_t        res;
  } directed_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // key_hash[31:0], value_type[34:32], value_word[66:35]
  logic [1:0]  in_tuser   = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // status[2:0], found_type[5:3], found_value[37:6],
                                  // entry_total[44:38]

  // table model state
  logic [HASH_W-1:0]  tbl_hash  [TABLE_DEPTH];
  logic [TYPE_W-1:0]  tbl_type  [TABLE_DEPTH];
  logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
  int                 tbl_count = 0;

  tbl_result_t   pending_results[$];
  directed_row_t directed[$];

  int error_count     = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int rand_items      = 0;
  int status_seen[5]  = '{default: 0};
  int req_seen[4]     = '{default: 0};

  bit quiet        = 1'b0;
  bit stall_wanted = 1'b0;
  bit stall_done   = 1'b0;
  int stall_left   = 0;

  sorted_hash_key_value_table #(.CAPACITY(TABLE_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one request to the table model and return the result it gives.
  function automatic tbl_result_t apply_request(logic [REQ_W-1:0] req, logic [HASH_W-1:0] key,
                                                logic [TYPE_W-1:0] vt, logic [VALUE_W-1:0] vw);
    tbl_result_t r;
    int lo, hi, mid, pos;
    bit hit;
    r = '{status: ST_OK, ftype: '0, fvalue: '0, total: '0};
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_hash[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    hit = (pos < tbl_count) && (tbl_hash[pos] == key);
    case (req)
      REQ_INSERT: begin
        if (hit) begin
          r.status = ST_DUP;
          r.ftype  = tbl_type[pos];
          r.fvalue = tbl_value[pos];
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_hash[i]  = tbl_hash[i-1];
            tbl_type[i]  = tbl_type[i-1];
            tbl_value[i] = tbl_value[i-1];
          end
          tbl_hash[pos]  = key;
          tbl_type[pos]  = vt;
          tbl_value[pos] = vw;
          tbl_count++;
          r.ftype  = vt;
          r.fvalue = vw;
        end
      end
      REQ_LOOKUP: begin
        if (hit) begin
          r.ftype  = tbl_type[pos];
          r.fvalue = tbl_value[pos];
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      REQ_UPDATE: begin
        if (!hit) begin
          r.status = ST_NOTFOUND;
        end else if (tbl_type[pos] != vt) begin
          r.status = ST_MISMATCH;
          r.ftype  = tbl_type[pos];
          r.fvalue = tbl_value[pos];
        end else begin
          tbl_value[pos] = vw;
          r.ftype  = vt;
          r.fvalue = vw;
        end
      end
      default: tbl_count = 0;
    endcase
    r.total = tbl_count[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic directed_row_t mk_row(logic [REQ_W-1:0] req, logic [HASH_W-1:0] key,
                                           logic [TYPE_W-1:0] vt, logic [VALUE_W-1:0] vw,
                                           bit typed, logic [STAT_W-1:0] st,
                                           logic [TYPE_W-1:0] ft, logic [VALUE_W-1:0] fv,
                                           logic [TOTAL_W-1:0] tot);
    directed_row_t row;
    row.req   = req;
    row.key   = key;
    row.vtype = vt;
    row.vword = vw;
    row.typed = typed;
    row.res   = '{status: st, ftype: ft, fvalue: fv, total: tot};
    return row;
  endfunction

  // Mostly random hashes, with extremes and near neighbors of stored hashes mixed in.
  function automatic logic [HASH_W-1:0] fresh_key();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 4 && tbl_count > 0) begin
      if (pick == 2) return tbl_hash[$urandom_range(0, tbl_count - 1)] + 1;
      return tbl_hash[$urandom_range(0, tbl_count - 1)] - 1;
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, want %h", results_checked, what, got, want);
    error_count++;
  endtask

  // Offer one request, hold it until accepted, then record its expected result.
  task automatic send_request(logic [REQ_W-1:0] req, logic [HASH_W-1:0] key,
                              logic [TYPE_W-1:0] vt, logic [VALUE_W-1:0] vw,
                              bit typed, tbl_result_t typed_res);
    tbl_result_t r;
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, vw, vt, key};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_request(req, key, vt, vw);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    requests_sent++;
    req_seen[req]++;
    if (r.status < 5) status_seen[r.status]++;
  endtask

  task automatic random_request(int target);
    logic [REQ_W-1:0]   req;
    logic [HASH_W-1:0]  key;
    logic [TYPE_W-1:0]  vt;
    logic [VALUE_W-1:0] vw;
    int pick, idx;
    bit known;
    pick  = $urandom_range(0, 99);
    vw    = $urandom;
    vt    = ($urandom_range(0, 3) == 0) ? TYPE_W'($urandom_range(0, 7))
                                        : TYPE_W'($urandom_range(0, 4));
    known = 1'b0;
    idx   = 0;
    if (pick == 0) req = REQ_CLEAR;
    else if (pick < ((tbl_count < target) ? 60 : 15)) req = REQ_INSERT;
    else if ($urandom_range(0, 1) == 0) req = REQ_LOOKUP;
    else req = REQ_UPDATE;
    if (tbl_count > 0) begin
      idx = $urandom_range(0, tbl_count - 1);
      if (req == REQ_INSERT) known = ($urandom_range(0, 4) == 0);
      else known = ($urandom_range(0, 3) != 0);
    end
    key = known ? tbl_hash[idx] : fresh_key();
    // Most updates of a stored key carry its type so the write goes through.
    if (req == REQ_UPDATE && known && $urandom_range(0, 3) != 0) vt = tbl_type[idx];
    send_request(req, key, vt, vw, 1'b0, '0);
    rand_items++;
    quiet        <= (rand_items >= 500 && rand_items < 700);
    stall_wanted <= (rand_items >= 250);
  endtask

  // receiver: random back-pressure, one long hold-off to fill the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_wanted && !stall_done) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk) begin
    tbl_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[2:0];
      got.ftype  = out_tdata[5:3];
      got.fvalue = out_tdata[37:6];
      got.total  = out_tdata[44:38];
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", got.fvalue, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.ftype != want.ftype) begin
          report_mismatch("found_type", 32'(got.ftype), 32'(want.ftype));
        end
        if (got.fvalue != want.fvalue) report_mismatch("found_value", got.fvalue, want.fvalue);
        if (got.total != want.total) begin
          report_mismatch("entry_total", 32'(got.total), 32'(want.total));
        end
      end
      results_checked++;
    end
  end

  initial begin
    int target, ops, episode;
    directed_row_t row;

    // empty table, extremes, duplicate, odd type code, mismatch, update, clear
    directed.push_back(mk_row(REQ_LOOKUP, 32'h0, 3'd0, 32'h0, 1, ST_NOTFOUND, 0, 0, 0));
    directed.push_back(mk_row(REQ_UPDATE, 32'hFFFF_FFFF, 3'd1, 32'h1, 1, ST_NOTFOUND, 0, 0, 0));
    directed.push_back(mk_row(REQ_INSERT, 32'h8000_0000, 3'd1, 32'h1234_5678, 1,
                              ST_OK, 3'd1, 32'h1234_5678, 1));
    directed.push_back(mk_row(REQ_INSERT, 32'h0, 3'd0, 32'h0, 1, ST_OK, 0, 0, 2));
    directed.push_back(mk_row(REQ_INSERT, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 1,
                              ST_OK, 3'd4, 32'hFFFF_FFFF, 3));
    directed.push_back(mk_row(REQ_INSERT, 32'h8000_0000, 3'd2, 32'h1, 1,
                              ST_DUP, 3'd1, 32'h1234_5678, 3));
    directed.push_back(mk_row(REQ_INSERT, 32'h5, 3'd7, 32'hA5A5_A5A5, 1,
                              ST_OK, 3'd7, 32'hA5A5_A5A5, 4));
    directed.push_back(mk_row(REQ_LOOKUP, 32'h0, 3'd5, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 4));
    directed.push_back(mk_row(REQ_LOOKUP, 32'hFFFF_FFFF, 3'd0, 32'h0, 1,
                              ST_OK, 3'd4, 32'hFFFF_FFFF, 4));
    directed.push_back(mk_row(REQ_LOOKUP, 32'h8000_0000, 3'd0, 32'h0, 1,
                              ST_OK, 3'd1, 32'h1234_5678, 4));
    directed.push_back(mk_row(REQ_LOOKUP, 32'h4, 3'd0, 32'h0, 1, ST_NOTFOUND, 0, 0, 4));
    directed.push_back(mk_row(REQ_UPDATE, 32'h8000_0000, 3'd2, 32'h0, 1,
                              ST_MISMATCH, 3'd1, 32'h1234_5678, 4));
    directed.push_back(mk_row(REQ_UPDATE, 32'h8000_0000, 3'd1, 32'hDEAD_BEEF, 1,
                              ST_OK, 3'd1, 32'hDEAD_BEEF, 4));
    directed.push_back(mk_row(REQ_UPDATE, 32'h5, 3'd7, 32'h5A5A_5A5A, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(REQ_LOOKUP, 32'h5, 3'd2, 32'h0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(REQ_INSERT, 32'h7FFF_FFFF, 3'd3, 32'h0F0F_0F0F, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(REQ_UPDATE, 32'h7FFF_FFFF, 3'd6, 32'h1, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(REQ_LOOKUP, 32'h8000_0000, 3'd0, 32'h0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(REQ_CLEAR, 32'h55, 3'd7, 32'hFFFF_FFFF, 1, ST_OK, 0, 0, 0));
    directed.push_back(mk_row(REQ_LOOKUP, 32'h0, 3'd0, 32'h0, 1, ST_NOTFOUND, 0, 0, 0));
    directed.push_back(mk_row(REQ_INSERT, 32'h1, 3'd2, 32'h2, 1, ST_OK, 3'd2, 32'h2, 1));
    directed.push_back(mk_row(REQ_CLEAR, 32'h0, 3'd0, 32'h0, 1, ST_OK, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.req, row.key, row.vtype, row.vword, row.typed, row.res);
    end

    // Each episode fills toward a target count, works on it, then clears.
    episode = 0;
    while (rand_items < RANDOM_COUNT) begin
      if (episode == 1 || $urandom_range(0, 5) == 0) target = TABLE_DEPTH;
      else target = $urandom_range(1, 12);
      ops = 2 * target + $urandom_range(4, 16);
      repeat (ops) random_request(target);
      send_request(REQ_CLEAR, $urandom, TYPE_W'($urandom_range(0, 7)), $urandom, 1'b0, '0);
      rand_items++;
      episode++;
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d requests (insert %0d, lookup %0d, update %0d, clear %0d), %0d results checked",
             requests_sent, req_seen[REQ_INSERT], req_seen[REQ_LOOKUP], req_seen[REQ_UPDATE],
             req_seen[REQ_CLEAR], results_checked);
    $display("statuses: ok %0d, not found %0d, duplicate %0d, full %0d, type mismatch %0d",
             status_seen[ST_OK], status_seen[ST_NOTFOUND], status_seen[ST_DUP],
             status_seen[ST_FULL], status_seen[ST_MISMATCH]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
